// ===== sv/tbo_pkg.sv =====
// Shared widths, constants and stage payload types for the triangle/box overlap pipeline.
// Used by every module of the block; depends on nothing.
package tbo_pkg;

  // Coordinate lane width and packed field width.
  localparam int CW = 16;
  localparam int FIELD_W = 3 * CW;
  localparam int IN_W = 6 * FIELD_W;
  // Output item: overlap flag plus three push lanes, padded to whole bytes.
  localparam int OW = 24;
  localparam int OUT_RAW_W = 1 + 3 * OW;
  localparam int OUT_W = ((OUT_RAW_W + 7) / 8) * 8;

  // Number of edge-cross axes.
  localparam int NAX = 9;
  // Box-centered doubled vertex and edge width.
  localparam int VW = 19;
  // Absolute edge component width.
  localparam int AW = 18;
  // Vertex times edge product and projection sum.
  localparam int PW = 2 * VW;
  localparam int PSW = PW + 1;
  // Box radius products and sum on an edge axis.
  localparam int RPW = CW + AW + 1;
  localparam int RSW = RPW + 1;
  // Plane distance products and sum.
  localparam int NPW = CW + VW;
  localparam int NSW = NPW + 2;
  // Plane radius products and sum.
  localparam int NRW = 2 * CW;
  localparam int NRSW = NRW + 2;
  // Overlap depth and push product.
  localparam int DW = NRSW;
  localparam int MW = CW + 1 + DW;

  // Normal fraction bits; the push product carries twice that plus the doubling.
  localparam int NORM_FRAC = 14;
  localparam int PUSH_SHIFT = 2 * NORM_FRAC + 1;
  // Rounded magnitude, one bit wider than a push lane so both bounds fit.
  localparam int QW = OW + 1;
  localparam logic [QW-1:0] PUSH_POS_MAX = QW'(8388607);
  localparam logic [QW-1:0] PUSH_NEG_MAX = QW'(8388608);

  // Products of one item after the multiply stage.
  typedef struct {
    logic signed [PW-1:0]  pa [NAX][3];
    logic signed [PW-1:0]  pb [NAX][3];
    logic        [RPW-1:0] ra [NAX];
    logic        [RPW-1:0] rb [NAX];
    logic signed [NPW-1:0] np [3];
    logic        [NRW-1:0] nr [3];
    logic                  face_sep;
    logic signed [CW-1:0]  n [3];
  } prod_t;

  // Decision after all separating-axis tests.
  typedef struct {
    logic                 overlap;
    logic [DW-1:0]        depth;
    logic signed [CW-1:0] n [3];
  } dec_t;

  // Final result item.
  typedef struct {
    logic                 overlap;
    logic signed [OW-1:0] push [3];
  } res_t;

endpackage

// ===== sv/tbo_prep.sv =====
// Front of the overlap pipeline: lane decode, box centering, edges, then all products.
// Two register stages with per-stage valid; depends on tbo_pkg.
module tbo_prep (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tbo_pkg::IN_W-1:0]     in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tbo_pkg::prod_t               out_data
);

  // Stage 1 registers: centered vertices, edges, extents, normal.
  logic                           s1_vld_r;
  logic signed [tbo_pkg::VW-1:0]  v_r [3][3];
  logic signed [tbo_pkg::VW-1:0]  f_r [3][3];
  logic        [tbo_pkg::CW-1:0]  e_r [3];
  logic signed [tbo_pkg::CW-1:0]  n_r [3];
  logic signed [tbo_pkg::VW-1:0]  v_nxt [3][3];
  logic signed [tbo_pkg::VW-1:0]  f_nxt [3][3];
  logic        [tbo_pkg::CW-1:0]  e_nxt [3];
  logic signed [tbo_pkg::CW-1:0]  n_nxt [3];

  // Stage 2 registers: products.
  logic           s2_vld_r;
  tbo_pkg::prod_t prod_r;
  tbo_pkg::prod_t prod_nxt;

  logic en1, en2;

  // A stage loads when it is empty or its contents move on.
  assign en2      = !s2_vld_r || out_ready;
  assign en1      = !s1_vld_r || en2;
  assign in_ready = en1;

  // Decode lanes, move the box to the origin with doubled coordinates, form edges.
  always_comb begin
    logic signed [tbo_pkg::CW-1:0] mn;
    logic        [tbo_pkg::CW-1:0] sz;
    logic signed [tbo_pkg::VW-1:0] c2;
    logic signed [tbo_pkg::CW-1:0] a;
    for (int i = 0; i < 3; i++) begin
      mn = in_data[4*tbo_pkg::FIELD_W + i*tbo_pkg::CW +: tbo_pkg::CW];
      sz = in_data[5*tbo_pkg::FIELD_W + i*tbo_pkg::CW +: tbo_pkg::CW];
      c2 = (tbo_pkg::VW'(mn) <<< 1) + $signed(tbo_pkg::VW'(sz));
      for (int t = 0; t < 3; t++) begin
        a = in_data[t*tbo_pkg::FIELD_W + i*tbo_pkg::CW +: tbo_pkg::CW];
        v_nxt[t][i] = (tbo_pkg::VW'(a) <<< 1) - c2;
      end
      e_nxt[i] = sz;
      n_nxt[i] = in_data[3*tbo_pkg::FIELD_W + i*tbo_pkg::CW +: tbo_pkg::CW];
    end
    for (int i = 0; i < 3; i++) begin
      f_nxt[0][i] = v_nxt[1][i] - v_nxt[0][i];
      f_nxt[1][i] = v_nxt[2][i] - v_nxt[1][i];
      f_nxt[2][i] = v_nxt[0][i] - v_nxt[2][i];
    end
  end

  // Products for each edge-cross axis (one per box axis and triangle edge), the plane test, and the box face test.
  always_comb begin
    int ax, j1, j2;
    logic signed [tbo_pkg::VW-1:0] f1, f2, hi, lo;
    logic        [tbo_pkg::AW-1:0] abs1, abs2;
    logic        [tbo_pkg::CW-1:0] absn;
    logic                          sep;
    sep = 1'b0;
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        ax = j * 3 + k;
        // The two other axes, cyclically after j.
        j1 = (j == 2) ? 0 : j + 1;
        j2 = (j == 0) ? 2 : j - 1;
        f1 = f_r[k][j1];
        f2 = f_r[k][j2];
        abs1 = f1[tbo_pkg::VW-1] ? tbo_pkg::AW'(-f1) : tbo_pkg::AW'(f1);
        abs2 = f2[tbo_pkg::VW-1] ? tbo_pkg::AW'(-f2) : tbo_pkg::AW'(f2);
        for (int t = 0; t < 3; t++) begin
          prod_nxt.pa[ax][t] = v_r[t][j1] * f2;
          prod_nxt.pb[ax][t] = v_r[t][j2] * f1;
        end
        prod_nxt.ra[ax] = tbo_pkg::RPW'(e_r[j1]) * tbo_pkg::RPW'(abs2);
        prod_nxt.rb[ax] = tbo_pkg::RPW'(e_r[j2]) * tbo_pkg::RPW'(abs1);
      end
    end
    for (int i = 0; i < 3; i++) begin
      absn = n_r[i][tbo_pkg::CW-1] ? -n_r[i] : n_r[i];
      prod_nxt.np[i] = n_r[i] * v_r[0][i];
      prod_nxt.nr[i] = tbo_pkg::NRW'(e_r[i]) * tbo_pkg::NRW'(absn);
      prod_nxt.n[i]  = n_r[i];
      hi = v_r[0][i];
      lo = v_r[0][i];
      for (int t = 1; t < 3; t++) begin
        if (v_r[t][i] > hi) hi = v_r[t][i];
        if (v_r[t][i] < lo) lo = v_r[t][i];
      end
      if (hi < -$signed(tbo_pkg::VW'(e_r[i])) || lo > $signed(tbo_pkg::VW'(e_r[i])))
        sep = 1'b1;
    end
    prod_nxt.face_sep = sep;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (en1) s1_vld_r <= in_valid;
      if (en2) s2_vld_r <= s1_vld_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      v_r <= v_nxt;
      f_r <= f_nxt;
      e_r <= e_nxt;
      n_r <= n_nxt;
    end
    if (en2 && s1_vld_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign out_valid = s2_vld_r;
  assign out_data  = prod_r;

endmodule

// ===== sv/tbo_sat.sv =====
// Middle of the overlap pipeline: projection sums, then the separating-axis decisions.
// Two register stages with per-stage valid; depends on tbo_pkg.
module tbo_sat (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tbo_pkg::prod_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output tbo_pkg::dec_t  out_data
);

  // Stage 3 registers: sums.
  logic                             s3_vld_r;
  logic signed [tbo_pkg::PSW-1:0]   p_r [tbo_pkg::NAX][3];
  logic        [tbo_pkg::RSW-1:0]   r_r [tbo_pkg::NAX];
  logic signed [tbo_pkg::NSW-1:0]   dot_r;
  logic        [tbo_pkg::NRSW-1:0]  pr_r;
  logic                             face_r;
  logic signed [tbo_pkg::CW-1:0]    n_r [3];
  logic signed [tbo_pkg::PSW-1:0]   p_nxt [tbo_pkg::NAX][3];
  logic        [tbo_pkg::RSW-1:0]   r_nxt [tbo_pkg::NAX];
  logic signed [tbo_pkg::NSW-1:0]   dot_nxt;
  logic        [tbo_pkg::NRSW-1:0]  pr_nxt;

  // Stage 4 registers: decision.
  logic          s4_vld_r;
  tbo_pkg::dec_t dec_r;
  tbo_pkg::dec_t dec_nxt;

  logic en3, en4;

  assign en4      = !s4_vld_r || out_ready;
  assign en3      = !s3_vld_r || en4;
  assign in_ready = en3;

  // Combine the product pairs into projections (difference) and radii (sum).
  always_comb begin
    for (int ax = 0; ax < tbo_pkg::NAX; ax++) begin
      for (int t = 0; t < 3; t++) begin
        p_nxt[ax][t] = tbo_pkg::PSW'(in_data.pb[ax][t]) - tbo_pkg::PSW'(in_data.pa[ax][t]);
      end
      r_nxt[ax] = tbo_pkg::RSW'(in_data.ra[ax]) + tbo_pkg::RSW'(in_data.rb[ax]);
    end
    dot_nxt = tbo_pkg::NSW'(in_data.np[0]) + tbo_pkg::NSW'(in_data.np[1])
            + tbo_pkg::NSW'(in_data.np[2]);
    pr_nxt  = tbo_pkg::NRSW'(in_data.nr[0]) + tbo_pkg::NRSW'(in_data.nr[1])
            + tbo_pkg::NRSW'(in_data.nr[2]);
  end

  // Strict separation tests on every axis; touching counts as overlap.
  always_comb begin
    logic signed [tbo_pkg::PSW:0]   hi, lo, lim;
    logic        [tbo_pkg::NSW-1:0] s;
    logic                           sep;
    sep = face_r;
    for (int ax = 0; ax < tbo_pkg::NAX; ax++) begin
      hi = (tbo_pkg::PSW + 1)'(p_r[ax][0]);
      lo = hi;
      for (int t = 1; t < 3; t++) begin
        if ((tbo_pkg::PSW + 1)'(p_r[ax][t]) > hi) hi = (tbo_pkg::PSW + 1)'(p_r[ax][t]);
        if ((tbo_pkg::PSW + 1)'(p_r[ax][t]) < lo) lo = (tbo_pkg::PSW + 1)'(p_r[ax][t]);
      end
      lim = (-hi > lo) ? -hi : lo;
      if ($signed((tbo_pkg::PSW + 1)'(r_r[ax])) < lim) sep = 1'b1;
    end
    s = dot_r[tbo_pkg::NSW-1] ? tbo_pkg::NSW'(-dot_r) : tbo_pkg::NSW'(dot_r);
    if (tbo_pkg::NSW'(pr_r) < s) sep = 1'b1;
    dec_nxt.overlap = !sep;
    dec_nxt.depth   = tbo_pkg::DW'(tbo_pkg::NSW'(pr_r) - s);
    dec_nxt.n       = n_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      if (en3) s3_vld_r <= in_valid;
      if (en4) s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && in_valid) begin
      p_r    <= p_nxt;
      r_r    <= r_nxt;
      dot_r  <= dot_nxt;
      pr_r   <= pr_nxt;
      face_r <= in_data.face_sep;
      n_r    <= in_data.n;
    end
    if (en4 && s3_vld_r) begin
      dec_r <= dec_nxt;
    end
  end

  assign out_valid = s4_vld_r;
  assign out_data  = dec_r;

endmodule

// ===== sv/tbo_push.sv =====
// Tail of the overlap pipeline: normal times depth, then rounding, saturation and output.
// Two register stages with per-stage valid; depends on tbo_pkg.
module tbo_push (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tbo_pkg::dec_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output tbo_pkg::res_t  out_data
);

  localparam logic [tbo_pkg::MW-1:0] HALF = tbo_pkg::MW'(1) << (tbo_pkg::PUSH_SHIFT - 1);

  // Stage 5 registers: magnitude products.
  logic                        s5_vld_r;
  logic [tbo_pkg::MW-1:0]      m_r [3];
  logic                        neg_r [3];
  logic                        ovl_r;
  logic [tbo_pkg::MW-1:0]      m_nxt [3];

  // Stage 6 registers: result.
  logic          s6_vld_r;
  tbo_pkg::res_t res_r;
  tbo_pkg::res_t res_nxt;

  logic en5, en6;

  assign en6      = !s6_vld_r || out_ready;
  assign en5      = !s5_vld_r || en6;
  assign in_ready = en5;

  // Magnitude of each normal lane times the depth.
  always_comb begin
    logic [tbo_pkg::CW:0] mag;
    for (int i = 0; i < 3; i++) begin
      mag = in_data.n[i][tbo_pkg::CW-1] ? (tbo_pkg::CW + 1)'(-in_data.n[i])
                                        : (tbo_pkg::CW + 1)'(in_data.n[i]);
      mag = in_data.n[i][tbo_pkg::CW-1] ? -(tbo_pkg::CW + 1)'(in_data.n[i]) : mag;
      m_nxt[i] = tbo_pkg::MW'(mag) * tbo_pkg::MW'(in_data.depth);
    end
  end

  // Round half away from zero, saturate, restore sign; no overlap gives zero.
  always_comb begin
    logic [tbo_pkg::MW-1:0] sum;
    logic [tbo_pkg::QW-1:0] q;
    for (int i = 0; i < 3; i++) begin
      sum = m_r[i] + HALF;
      q   = tbo_pkg::QW'(sum >> tbo_pkg::PUSH_SHIFT);
      if (neg_r[i]) begin
        if (q > tbo_pkg::PUSH_NEG_MAX) q = tbo_pkg::PUSH_NEG_MAX;
        res_nxt.push[i] = ovl_r ? -$signed(tbo_pkg::OW'(q)) : '0;
      end else begin
        if (q > tbo_pkg::PUSH_POS_MAX) q = tbo_pkg::PUSH_POS_MAX;
        res_nxt.push[i] = ovl_r ? $signed(tbo_pkg::OW'(q)) : '0;
      end
    end
    res_nxt.overlap = ovl_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
    end else begin
      if (en5) s5_vld_r <= in_valid;
      if (en6) s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en5 && in_valid) begin
      m_r   <= m_nxt;
      ovl_r <= in_data.overlap;
      for (int i = 0; i < 3; i++) neg_r[i] <= in_data.n[i][tbo_pkg::CW-1];
    end
    if (en6 && s5_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = s6_vld_r;
  assign out_data  = res_r;

endmodule

// ===== sv/triangle_box_overlap_test_top.sv =====
// Pipeline: six register stages (decode/edges, products, sums, axis decisions, push product,
// rounding); the result is registered in the last of these.
// Throughput: one triangle/box pair per cycle; each stage holds its item while the next
// stage is full, so a stall on the result side backs up stage by stage.
// Reset: rst_n synchronous, active low, clears every stage valid bit; no other state.
// Depends on tbo_pkg, tbo_prep, tbo_sat and tbo_push.
module triangle_box_overlap_test_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // vertex_a, vertex_b, vertex_c, face_normal, box_min, box_size (48 bits each)
  input  logic [tbo_pkg::IN_W-1:0]     in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // overlap[0], push_x[24:1], push_y[48:25], push_z[72:49], zero pad above
  output logic [tbo_pkg::OUT_W-1:0]    out_tdata
);

  logic           prep_valid, prep_ready;
  tbo_pkg::prod_t prep_data;
  logic           sat_valid, sat_ready;
  tbo_pkg::dec_t  sat_data;
  tbo_pkg::res_t  res;

  // Decode and multiply.
  tbo_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_data  (prep_data)
  );

  // Axis tests.
  tbo_sat u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_data   (prep_data),
    .out_valid (sat_valid),
    .out_ready (sat_ready),
    .out_data  (sat_data)
  );

  // Push-out vector.
  tbo_push u_push (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sat_valid),
    .in_ready  (sat_ready),
    .in_data   (sat_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res)
  );

  // Pack the result transfer.
  assign out_tdata = {{(tbo_pkg::OUT_W - tbo_pkg::OUT_RAW_W){1'b0}},
                      res.push[2], res.push[1], res.push[0], res.overlap};

  // A separated pair never carries a push vector.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[tbo_pkg::OUT_RAW_W-1:1] == '0)
    else $error("push vector nonzero without overlap");

  // Input back-pressure only arises from a full pipe with a waiting result.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while output side is free");

  // Pad bits above the packed result stay zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[tbo_pkg::OUT_W-1:tbo_pkg::OUT_RAW_W] == '0)
    else $error("result pad bits set");

endmodule

// ===== tb/tb_triangle_box_overlap_test_top.sv =====
// Self-checking testbench for the triangle/box separating-axis overlap pipeline.
// Depends on tbo_pkg and triangle_box_overlap_test_top; drives directed and random pairs.
module tb_triangle_box_overlap_test_top;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1950;

  // Local copies of the package widths.
  localparam int CW = tbo_pkg::CW;
  localparam int FIELD_W = tbo_pkg::FIELD_W;
  localparam int IN_W = tbo_pkg::IN_W;
  localparam int OW = tbo_pkg::OW;
  localparam int OUT_W = tbo_pkg::OUT_W;
  localparam int OUT_RAW_W = tbo_pkg::OUT_RAW_W;
  localparam int PUSH_SHIFT = tbo_pkg::PUSH_SHIFT;

  // One triangle/box pair as it travels on the input stream.
  typedef struct packed {
    logic [FIELD_W-1:0] box_size;
    logic [FIELD_W-1:0] box_min;
    logic [FIELD_W-1:0] face_normal;
    logic [FIELD_W-1:0] vertex_c;
    logic [FIELD_W-1:0] vertex_b;
    logic [FIELD_W-1:0] vertex_a;
  } pair_t;

  // Expected result with its packed form.
  typedef struct packed {
    logic               overlap;
    logic [OW-1:0]      push_x;
    logic [OW-1:0]      push_y;
    logic [OW-1:0]      push_z;
  } push_t;

  // Directed row: a pair and, where known at a glance, its result.
  typedef struct {
    pair_t pair;
    bit    fixed;
    push_t result;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;

  push_t expected_pushes[$];
  int    error_count = 0;
  int    idle_cycles = 0;
  bit    calm_sender;
  bit    calm_receiver;
  row_t  rows[$];

  triangle_box_overlap_test_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sign-extend one signed 16-bit lane to 64 bits.
  function automatic longint signed lane_s(logic [FIELD_W-1:0] f, int k);
    logic signed [CW-1:0] v;
    v = f[k*CW +: CW];
    return longint'(v);
  endfunction

  function automatic longint signed lane_u(logic [FIELD_W-1:0] f, int k);
    return longint'({48'd0, f[k*CW +: CW]});
  endfunction

  function automatic longint signed abs64(longint signed a);
    return (a < 0) ? -a : a;
  endfunction

  // Round the normal times depth to the coordinate step and saturate.
  function automatic logic [OW-1:0] push_component(longint signed n, longint signed d);
    longint unsigned q;
    q = (longint'(abs64(n)) * d + (64'd1 << (PUSH_SHIFT - 1))) >> PUSH_SHIFT;
    if (n < 0) begin
      if (q > 64'd8388608) q = 64'd8388608;
      return OW'(-longint'(q));
    end
    if (q > 64'd8388607) q = 64'd8388607;
    return OW'(q);
  endfunction

  // Separating-axis test on doubled, box-centered coordinates.
  function automatic push_t predict_push(pair_t p);
    longint signed vtx[3][3], half[3], nrm[3], edg[3][3], ax[3];
    longint signed r, s, p0, p1, p2, hi, lo, c2;
    logic [FIELD_W-1:0] corners[3];
    push_t res;
    bit sep;
    corners[0] = p.vertex_a;
    corners[1] = p.vertex_b;
    corners[2] = p.vertex_c;
    sep = 1'b0;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      c2 = 2 * lane_s(p.box_min, i) + lane_u(p.box_size, i);
      for (int t = 0; t < 3; t++) vtx[t][i] = 2 * lane_s(corners[t], i) - c2;
      half[i] = lane_u(p.box_size, i);
      nrm[i] = lane_s(p.face_normal, i);
    end
    for (int i = 0; i < 3; i++) begin
      edg[0][i] = vtx[1][i] - vtx[0][i];
      edg[1][i] = vtx[2][i] - vtx[1][i];
      edg[2][i] = vtx[0][i] - vtx[2][i];
    end
    // Edge-cross axes, one per box axis and triangle edge.
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        ax[j] = 0;
        ax[(j + 1) % 3] = -edg[k][(j + 2) % 3];
        ax[(j + 2) % 3] = edg[k][(j + 1) % 3];
        r = half[0] * abs64(ax[0]) + half[1] * abs64(ax[1]) + half[2] * abs64(ax[2]);
        p0 = vtx[0][0] * ax[0] + vtx[0][1] * ax[1] + vtx[0][2] * ax[2];
        p1 = vtx[1][0] * ax[0] + vtx[1][1] * ax[1] + vtx[1][2] * ax[2];
        p2 = vtx[2][0] * ax[0] + vtx[2][1] * ax[1] + vtx[2][2] * ax[2];
        hi = (p0 > p1) ? p0 : p1;
        hi = (hi > p2) ? hi : p2;
        lo = (p0 < p1) ? p0 : p1;
        lo = (lo < p2) ? lo : p2;
        if (r < ((-hi > lo) ? -hi : lo)) sep = 1'b1;
      end
    end
    // Box face axes.
    for (int i = 0; i < 3; i++) begin
      hi = (vtx[0][i] > vtx[1][i]) ? vtx[0][i] : vtx[1][i];
      hi = (hi > vtx[2][i]) ? hi : vtx[2][i];
      lo = (vtx[0][i] < vtx[1][i]) ? vtx[0][i] : vtx[1][i];
      lo = (lo < vtx[2][i]) ? lo : vtx[2][i];
      if (hi < -half[i] || half[i] < lo) sep = 1'b1;
    end
    // Triangle plane.
    s = abs64(nrm[0] * vtx[0][0] + nrm[1] * vtx[0][1] + nrm[2] * vtx[0][2]);
    r = half[0] * abs64(nrm[0]) + half[1] * abs64(nrm[1]) + half[2] * abs64(nrm[2]);
    if (r < s) sep = 1'b1;
    if (!sep) begin
      res.overlap = 1'b1;
      res.push_x = push_component(nrm[0], r - s);
      res.push_y = push_component(nrm[1], r - s);
      res.push_z = push_component(nrm[2], r - s);
    end
    return res;
  endfunction

  function automatic logic [FIELD_W-1:0] pack3(int x, int y, int z);
    return {CW'(z), CW'(y), CW'(x)};
  endfunction

  function automatic logic [FIELD_W-1:0] rand_field();
    return {16'($urandom_range(65535)), $urandom()};
  endfunction

  // Small coordinates near the box, within +-span on each lane so overlaps are common.
  function automatic logic [FIELD_W-1:0] near_field(int span);
    int x, y, z;
    x = int'($urandom_range(2 * span)) - span;
    y = int'($urandom_range(2 * span)) - span;
    z = int'($urandom_range(2 * span)) - span;
    return pack3(x, y, z);
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int kind;
    kind = $urandom_range(9);
    if (kind < 2) begin
      p = {rand_field(), rand_field(), rand_field(), rand_field(), rand_field(), rand_field()};
    end else begin
      p.vertex_a = near_field(1024);
      p.vertex_b = near_field(1024);
      p.vertex_c = (kind == 2) ? p.vertex_a : near_field(1024);
      p.face_normal = (kind == 3) ? '0 : near_field(16384);
      p.box_min = near_field(768);
      p.box_size = pack3($urandom_range(1024), $urandom_range(1024), $urandom_range(1024));
    end
    return p;
  endfunction

  // Push one pair through the input handshake and record its expectation.
  // Called at a falling edge; returns at the falling edge after the transfer, with
  // in_tvalid still high so the next pair can follow without a gap.
  task automatic send_pair(pair_t p, bit fixed, push_t result);
    while (!calm_sender && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_pushes.insert(expected_pushes.size(), fixed ? result : predict_push(p));
    @(negedge clk);
  endtask

  // Directed table: extremes and the named special cases.
  task automatic build_rows();
    row_t r;
    push_t none;
    none = '0;
    r.fixed = 1'b0;
    r.result = none;
    // Far apart on the x face: separated.
    r.pair = {pack3(256, 256, 256), pack3(0, 0, 0), pack3(0, 0, 16384),
              pack3(5000, 0, 0), pack3(5256, 0, 0), pack3(5000, 256, 0)};
    r.fixed = 1'b1;
    rows.insert(rows.size(), r);
    // Triangle in plane z=0 through a 512-wide box centered at origin.
    r.fixed = 1'b0;
    r.pair = {pack3(512, 512, 512), pack3(-256, -256, -256), pack3(0, 0, 16384),
              pack3(-512, -512, 0), pack3(512, -512, 0), pack3(0, 512, 0)};
    rows.insert(rows.size(), r);
    // Zero normal.
    r.pair.face_normal = '0;
    rows.insert(rows.size(), r);
    // Negative normal, unnormalized.
    r.pair.face_normal = pack3(-32768, 32767, -32768);
    rows.insert(rows.size(), r);
    // Box touching the plane exactly.
    r.pair = {pack3(256, 256, 256), pack3(0, 0, 0), pack3(0, 0, 16384),
              pack3(-512, -512, 0), pack3(512, -512, 0), pack3(0, 512, 0)};
    rows.insert(rows.size(), r);
    // Face contact on the x axis.
    r.pair = {pack3(256, 256, 256), pack3(0, 0, 0), pack3(16384, 0, 0),
              pack3(256, 0, 0), pack3(256, 256, 0), pack3(256, 0, 256)};
    rows.insert(rows.size(), r);
    // Degenerate triangle, all vertices equal inside the box.
    r.pair = {pack3(512, 512, 512), pack3(0, 0, 0), pack3(0, 16384, 0),
              pack3(128, 128, 128), pack3(128, 128, 128), pack3(128, 128, 128)};
    rows.insert(rows.size(), r);
    // Extremes: all ones, all zeros, maximum box with extreme normal.
    r.pair = '1;
    rows.insert(rows.size(), r);
    r.pair = '0;
    rows.insert(rows.size(), r);
    r.pair = {pack3(65535, 65535, 65535), pack3(-32768, -32768, -32768),
              pack3(32767, -32768, 32767), pack3(32767, 32767, 32767),
              pack3(-32768, -32768, -32768), pack3(32767, -32768, 0)};
    rows.insert(rows.size(), r);
    r.pair = {pack3(65535, 65535, 65535), pack3(-32768, -32768, -32768),
              pack3(-32768, -32768, -32768), pack3(0, 0, 0), pack3(100, 0, 0),
              pack3(0, 100, 0)};
    rows.insert(rows.size(), r);
    r.pair = {pack3(65535, 65535, 65535), pack3(-32768, -32768, -32768),
              pack3(32767, 32767, 32767), pack3(0, 0, 0), pack3(100, 0, 0),
              pack3(0, 100, 0)};
    rows.insert(rows.size(), r);
  endtask

  // Receiver: random stalls, compare each transfer with the oldest expectation.
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= calm_receiver || ($urandom_range(99) >= 18);
  end

  always @(posedge clk) begin
    push_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[0], out_tdata[24:1], out_tdata[48:25], out_tdata[72:49]};
      if (expected_pushes.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        error_count++;
      end else begin
        want = expected_pushes.pop_front();
        if (got.overlap !== want.overlap) begin
          $display("%0t: overlap expected %b actual %b", $time, want.overlap, got.overlap);
          error_count++;
        end
        if (got.push_x !== want.push_x) begin
          $display("%0t: push_x expected %h actual %h", $time, want.push_x, got.push_x);
          error_count++;
        end
        if (got.push_y !== want.push_y) begin
          $display("%0t: push_y expected %h actual %h", $time, want.push_y, got.push_y);
          error_count++;
        end
        if (got.push_z !== want.push_z) begin
          $display("%0t: push_z expected %h actual %h", $time, want.push_z, got.push_z);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    push_t none;
    none = '0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    calm_sender = 1'b0;
    calm_receiver = 1'b0;
    build_rows();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (rows[i]) send_pair(rows[i].pair, rows[i].fixed, rows[i].result);
    in_tvalid <= 1'b0;
    // Hold off until every directed result has come back.
    while (expected_pushes.size() != 0) @(posedge clk);
    @(negedge clk);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm_sender = (n >= 600 && n < 900);
      calm_receiver = calm_sender;
      send_pair(random_pair(), 1'b0, none);
    end
    in_tvalid <= 1'b0;
    calm_sender = 1'b0;
    calm_receiver = 1'b0;
    while (expected_pushes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
